@@ design/umif_pkg.sv @@
// shared types, descriptor codes and record helpers for the midi interface finder
`default_nettype none

package umif_pkg;

   // result status codes
   localparam logic [1:0] STATUS_FOUND     = 2'd0;
   localparam logic [1:0] STATUS_NONE      = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   // descriptor types and class codes
   localparam logic [7:0] DESC_CONFIG             = 8'd2;
   localparam logic [7:0] DESC_INTERFACE          = 8'd4;
   localparam logic [7:0] DESC_ENDPOINT           = 8'd5;
   localparam logic [7:0] CLASS_AUDIO             = 8'd1;
   localparam logic [7:0] SUBCLASS_MIDI_STREAMING = 8'd3;
   localparam logic [7:0] PROTOCOL_NONE           = 8'd0;

   // length limits
   localparam logic [7:0] MIN_CONFIG_LEN    = 8'd9;
   localparam logic [7:0] MIN_INTERFACE_LEN = 8'd9;
   localparam logic [7:0] MIN_ENDPOINT_LEN  = 8'd7;
   localparam logic [7:0] MIN_DESC_LEN      = 8'd2;

   // endpoint fields
   localparam logic [7:0]  EP_NUM_MASK    = 8'h0F;
   localparam logic [7:0]  EP_DIR_IN      = 8'h80;
   localparam logic [1:0]  XFER_BULK      = 2'd2;
   localparam logic [1:0]  XFER_INTERRUPT = 2'd3;
   localparam logic [10:0] MIN_MAX_PACKET = 11'd4;

   // byte positions inside the configuration header
   localparam logic [15:0] POS_HEADER_TYPE  = 16'd1;
   localparam logic [15:0] POS_HEADER_TOTAL = 16'd3;
   localparam logic [15:0] POS_HEADER_END   = 16'd4;
   localparam logic [15:0] POS_MAX          = 16'hFFFF;

   localparam int RSP_DATA_W = 56;

   typedef struct packed {
      logic [7:0]  num;
      logic [7:0]  alt;
      logic [7:0]  in_ep;
      logic [10:0] in_mps;
      logic [7:0]  out_ep;
      logic [10:0] out_mps;
   } rec_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      rec_type    rec;
   } rsp_item_type;

   // held record is replaced when empty, or when the candidate has both directions and it has not
   function automatic rec_type keep_better(rec_type cand, rec_type best);
      logic best_empty;
      logic cand_both;
      logic best_both;
      best_empty = (best.in_ep == 8'd0) && (best.out_ep == 8'd0);
      cand_both  = (cand.in_ep != 8'd0) && (cand.out_ep != 8'd0);
      best_both  = (best.in_ep != 8'd0) && (best.out_ep != 8'd0);
      if (best_empty || (cand_both && !best_both)) begin
         return cand;
      end
      return best;
   endfunction

endpackage

`default_nettype wire

@@ design/umif_in_stage.sv @@
// input register for request bytes
`default_nettype none

module umif_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   pop,
   output umif_pkg::req_item_type      item
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       load;

   assign req_tready = !valid_ff || pop;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = data_ff;
   assign item.last      = last_ff;

endmodule

`default_nettype wire

@@ design/umif_parser.sv @@
// descriptor walk state, interface candidate tracking and result formation
`default_nettype none

module umif_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   go,
   input  wire umif_pkg::req_item_type item,
   output logic                        fire,
   output umif_pkg::rsp_item_type      result
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  off_ff, off_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  cap_ff [6];
   logic [7:0]  cap_in [6];
   logic        inside_ff, inside_in;
   logic        mal_ff, mal_in;
   umif_pkg::rec_type cand_ff, cand_in;
   umif_pkg::rec_type best_ff, best_in;
   umif_pkg::rec_type final_best;

   logic [7:0]  b;
   logic        take;
   logic        bad;
   logic        fin;
   logic [7:0]  kind_eff;
   logic [7:0]  dlen_eff;
   logic [15:0] new_total;
   logic [15:0] room;
   logic [16:0] count;
   logic [7:0]  ep_addr;
   logic [1:0]  ep_type;
   logic [10:0] ep_mps;
   logic        ep_ok;

   assign b         = item.data_byte;
   assign kind_eff  = (off_ff == 8'd1) ? b : kind_ff;
   assign dlen_eff  = (off_ff == 8'd0) ? b : dlen_ff;
   assign new_total = {b, cap_ff[0]};
   assign room      = total_ff - pos_ff;
   assign fin       = ({1'b0, off_ff} + 9'd1) >= {1'b0, dlen_eff};
   assign take      = !mal_ff && ((pos_ff < umif_pkg::POS_HEADER_END) || (pos_ff < total_ff));
   assign count     = {1'b0, pos_ff} + 17'd1;

   // endpoint fields, all from bytes captured earlier in this descriptor
   assign ep_addr = cap_ff[0];
   assign ep_type = cap_ff[1][1:0];
   assign ep_mps  = {cap_ff[3][2:0], cap_ff[2]};
   assign ep_ok   = ((ep_type == umif_pkg::XFER_BULK) || (ep_type == umif_pkg::XFER_INTERRUPT))
                    && ((ep_addr & umif_pkg::EP_NUM_MASK) != 8'd0)
                    && (ep_mps >= umif_pkg::MIN_MAX_PACKET);

   always_comb begin
      pos_in    = pos_ff;
      total_in  = total_ff;
      off_in    = off_ff;
      dlen_in   = dlen_ff;
      kind_in   = kind_ff;
      cap_in    = cap_ff;
      inside_in = inside_ff;
      mal_in    = mal_ff;
      cand_in   = cand_ff;
      best_in   = best_ff;
      bad       = 1'b0;
      fire      = 1'b0;

      if (go) begin
         pos_in = (pos_ff == umif_pkg::POS_MAX) ? pos_ff : pos_ff + 16'd1;
         if (take) begin
            if (off_ff == 8'd0) begin
               dlen_in = b;
               if (pos_ff == 16'd0) begin
                  bad = b < umif_pkg::MIN_CONFIG_LEN;
               end else begin
                  bad = (b < umif_pkg::MIN_DESC_LEN) || ({8'd0, b} > room);
               end
            end else if (off_ff == 8'd1) begin
               kind_in = b;
               bad = ((pos_ff == umif_pkg::POS_HEADER_TYPE) && (b != umif_pkg::DESC_CONFIG))
                  || ((b == umif_pkg::DESC_INTERFACE) && (dlen_ff < umif_pkg::MIN_INTERFACE_LEN))
                  || ((b == umif_pkg::DESC_ENDPOINT) && inside_ff
                      && (dlen_ff < umif_pkg::MIN_ENDPOINT_LEN));
            end else begin
               for (int i = 0; i < 6; i++) begin
                  if (off_ff == 8'(i + 2)) begin
                     cap_in[i] = b;
                  end
               end
            end

            // total length arrives in header bytes two and three
            if (pos_ff == umif_pkg::POS_HEADER_TOTAL) begin
               total_in = new_total;
               if ((new_total < {8'd0, umif_pkg::MIN_CONFIG_LEN})
                   || ({8'd0, dlen_ff} > new_total)) begin
                  bad = 1'b1;
               end
            end

            if (bad) begin
               mal_in = 1'b1;
            end else if (fin) begin
               off_in = 8'd0;
               if (kind_eff == umif_pkg::DESC_INTERFACE) begin
                  best_in      = umif_pkg::keep_better(cand_ff, best_ff);
                  cand_in      = '0;
                  cand_in.num  = cap_ff[0];
                  cand_in.alt  = cap_ff[1];
                  inside_in    = (cap_ff[3] == umif_pkg::CLASS_AUDIO)
                              && (cap_ff[4] == umif_pkg::SUBCLASS_MIDI_STREAMING)
                              && (cap_ff[5] == umif_pkg::PROTOCOL_NONE);
               end else if ((kind_eff == umif_pkg::DESC_ENDPOINT) && inside_ff && ep_ok) begin
                  if (((ep_addr & umif_pkg::EP_DIR_IN) != 8'd0) && (cand_ff.in_ep == 8'd0)) begin
                     cand_in.in_ep  = ep_addr;
                     cand_in.in_mps = ep_mps;
                  end else if (((ep_addr & umif_pkg::EP_DIR_IN) == 8'd0)
                               && (cand_ff.out_ep == 8'd0)) begin
                     cand_in.out_ep  = ep_addr;
                     cand_in.out_mps = ep_mps;
                  end
               end
            end else begin
               off_in = off_ff + 8'd1;
            end
         end
      end

      final_best    = umif_pkg::keep_better(cand_in, best_in);
      result.rec    = '0;
      if (mal_in || (count < {9'd0, umif_pkg::MIN_CONFIG_LEN}) || (count < {1'b0, total_in})) begin
         result.status = umif_pkg::STATUS_MALFORMED;
      end else if ((final_best.in_ep != 8'd0) || (final_best.out_ep != 8'd0)) begin
         result.status = umif_pkg::STATUS_FOUND;
         result.rec    = final_best;
      end else begin
         result.status = umif_pkg::STATUS_NONE;
      end

      // end of buffer: report and start over
      if (go && item.last) begin
         fire      = 1'b1;
         pos_in    = '0;
         total_in  = '0;
         off_in    = '0;
         dlen_in   = '0;
         kind_in   = '0;
         inside_in = 1'b0;
         mal_in    = 1'b0;
         cand_in   = '0;
         best_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         total_ff  <= '0;
         off_ff    <= '0;
         dlen_ff   <= '0;
         kind_ff   <= '0;
         inside_ff <= 1'b0;
         mal_ff    <= 1'b0;
         cand_ff   <= '0;
         best_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         total_ff  <= total_in;
         off_ff    <= off_in;
         dlen_ff   <= dlen_in;
         kind_ff   <= kind_in;
         inside_ff <= inside_in;
         mal_ff    <= mal_in;
         cand_ff   <= cand_in;
         best_ff   <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

endmodule

`default_nettype wire

@@ design/umif_rsp_stage.sv @@
// result register towards the response channel
`default_nettype none

module umif_rsp_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire umif_pkg::rsp_item_type result,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output umif_pkg::rsp_item_type      rsp_item,
   output logic                        free
);

   logic                   valid_ff, valid_in;
   umif_pkg::rsp_item_type item_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = fire || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

`default_nettype wire

@@ design/usb_midi_interface_finder.sv @@
// top level of the usb midi streaming interface finder
`default_nettype none

// walks a usb configuration descriptor set, one byte per request, and picks the
// audio / midi streaming interface to use, with its first usable bulk or interrupt
// in and out endpoints. a request is one byte; tlast marks the final byte of the
// buffer and only that byte produces a response (found, none, or malformed). the
// block takes one byte every clock cycle unless held back: each byte is registered
// on entry and parsed by a single pass of counters and compares while it sits in
// that register, and the response for a final byte is loaded into the output
// register at the edge at which that byte leaves the input register.
// the only back-pressure comes from the response register: a final byte waits
// while an earlier response has not yet been taken, and requests behind it wait
// too. after each response all parse state but the captured descriptor bytes
// returns to its reset value, ready for the next buffer
module usb_midi_interface_finder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte [7:0]
   input  wire logic        req_tlast,   // last byte of the buffer
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [umif_pkg::RSP_DATA_W-1:0] rsp_tdata
   // rsp_tdata: status [1:0], interface_number [9:2], alternate_setting [17:10],
   // in_endpoint [25:18], in_max_packet [36:26], out_endpoint [44:37],
   // out_max_packet [55:45]
);

   umif_pkg::req_item_type item;
   umif_pkg::rsp_item_type result;
   umif_pkg::rsp_item_type rsp_item;
   logic                   pop;
   logic                   fire;
   logic                   out_free;

   // a non-final byte always moves on; a final one needs room for its response
   assign pop = item.valid && (!item.last || out_free);

   umif_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .item       (item)
   );

   umif_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .go     (pop),
      .item   (item),
      .fire   (fire),
      .result (result)
   );

   umif_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .free       (out_free)
   );

   // pack the response fields, first field in the lowest bits
   assign rsp_tdata = {rsp_item.rec.out_mps,
                       rsp_item.rec.out_ep,
                       rsp_item.rec.in_mps,
                       rsp_item.rec.in_ep,
                       rsp_item.rec.alt,
                       rsp_item.rec.num,
                       rsp_item.status};

endmodule

`default_nettype wire

@@ design/umif_checker.sv @@
// port level checks for the midi interface finder, bound to the top level
`default_nettype none

module umif_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // only found, none or malformed are reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= umif_pkg::STATUS_MALFORMED)
      else $error("undefined status code");

   // anything but found carries zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != umif_pkg::STATUS_FOUND |-> rsp_tdata[55:2] == 54'd0)
      else $error("fields set without a found status");

   // found always names at least one endpoint
   a_found_endpoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == umif_pkg::STATUS_FOUND
      |-> rsp_tdata[25:18] != 8'd0 || rsp_tdata[44:37] != 8'd0)
      else $error("found status without an endpoint");

endmodule

bind usb_midi_interface_finder umif_checker u_umif_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ sim/tb_usb_midi_interface_finder.sv @@
// self-checking testbench for the usb midi streaming interface finder
module tb_usb_midi_interface_finder;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_BYTES  = 1450;
   localparam int RANDOM_BUFS   = 25;
   localparam int DRAIN_CYCLES  = 16;
   localparam int LONG_RUN      = 120;

   // descriptor codes that only the stimulus needs
   localparam logic [7:0] DESC_CS_INTERFACE      = 8'h24;
   localparam logic [7:0] DESC_CS_ENDPOINT       = 8'h25;
   localparam logic [7:0] SUBCLASS_AUDIO_CONTROL = 8'd1;
   localparam logic [1:0] XFER_CONTROL           = 2'd0;
   localparam logic [1:0] XFER_ISOCHRONOUS       = 2'd1;
   localparam logic [7:0] ATTR_BULK              = {6'd0, umif_pkg::XFER_BULK};
   localparam logic [7:0] ATTR_INTR              = {6'd0, umif_pkg::XFER_INTERRUPT};

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } beat_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = 8'd0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [umif_pkg::RSP_DATA_W-1:0] rsp_tdata;

   usb_midi_interface_finder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // parser mirror: tracks the walk through the descriptor set, one request at a
   // time, and yields the verdict expected on the final byte of each buffer
   // ---------------------------------------------------------------------------
   logic [15:0]       scan_pos;
   logic [15:0]       cfg_total;
   logic [7:0]        desc_off;
   logic [7:0]        desc_len;
   logic [7:0]        desc_kind;
   logic [7:0]        field_bytes [6];   // bytes 2..7 of the current descriptor
   logic              in_midi;
   umif_pkg::rec_type cand_rec;
   umif_pkg::rec_type held_rec;
   logic              bad_seen;

   umif_pkg::rsp_item_type awaited_verdicts [$];
   beat_type               req_backlog [$];
   logic [7:0]             draft [$];         // buffer under construction

   int error_count = 0;
   int rsp_count   = 0;
   int cycle_count = 0;

   function automatic void clear_parser();
      scan_pos  = '0;
      cfg_total = '0;
      desc_off  = '0;
      desc_len  = '0;
      desc_kind = '0;
      for (int i = 0; i < 6; i++) field_bytes[i] = '0;
      in_midi   = 1'b0;
      cand_rec  = '0;
      held_rec  = '0;
      bad_seen  = 1'b0;
   endfunction

   // an empty held record always gives way; otherwise only a two-way candidate
   // displaces a one-way held record
   function automatic void promote_candidate();
      logic held_empty;
      logic cand_both;
      logic held_both;
      held_empty = (held_rec.in_ep == 8'd0) && (held_rec.out_ep == 8'd0);
      cand_both  = (cand_rec.in_ep != 8'd0) && (cand_rec.out_ep != 8'd0);
      held_both  = (held_rec.in_ep != 8'd0) && (held_rec.out_ep != 8'd0);
      if (held_empty || (cand_both && !held_both)) begin
         held_rec = cand_rec;
      end
   endfunction

   function automatic void close_descriptor();
      logic [7:0]  addr;
      logic [1:0]  xfer;
      logic [10:0] mps;
      if (desc_kind == umif_pkg::DESC_INTERFACE) begin
         promote_candidate();
         cand_rec     = '0;
         cand_rec.num = field_bytes[0];
         cand_rec.alt = field_bytes[1];
         in_midi = (field_bytes[3] == umif_pkg::CLASS_AUDIO) &&
                   (field_bytes[4] == umif_pkg::SUBCLASS_MIDI_STREAMING) &&
                   (field_bytes[5] == umif_pkg::PROTOCOL_NONE);
      end else if (desc_kind == umif_pkg::DESC_ENDPOINT && in_midi) begin
         addr = field_bytes[0];
         xfer = field_bytes[1][1:0];
         mps  = {field_bytes[3][2:0], field_bytes[2]};
         if ((xfer == umif_pkg::XFER_BULK || xfer == umif_pkg::XFER_INTERRUPT) &&
             ((addr & umif_pkg::EP_NUM_MASK) != 8'd0) &&
             (mps >= umif_pkg::MIN_MAX_PACKET)) begin
            if ((addr & umif_pkg::EP_DIR_IN) != 8'd0) begin
               if (cand_rec.in_ep == 8'd0) begin
                  cand_rec.in_ep  = addr;
                  cand_rec.in_mps = mps;
               end
            end else if (cand_rec.out_ep == 8'd0) begin
               cand_rec.out_ep  = addr;
               cand_rec.out_mps = mps;
            end
         end
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      logic [15:0] pos;
      logic [7:0]  off;
      pos = scan_pos;
      off = desc_off;
      if (off == 8'd0) begin
         desc_len = b;
         if (pos == 16'd0) begin
            if (b < umif_pkg::MIN_CONFIG_LEN) begin
               bad_seen = 1'b1;
               return;
            end
         end else if (b < umif_pkg::MIN_DESC_LEN ||
                      int'(b) > int'(cfg_total) - int'(pos)) begin
            bad_seen = 1'b1;
            return;
         end
      end else if (off == 8'd1) begin
         desc_kind = b;
         if (pos == umif_pkg::POS_HEADER_TYPE && b != umif_pkg::DESC_CONFIG) begin
            bad_seen = 1'b1;
            return;
         end
         if (b == umif_pkg::DESC_INTERFACE && desc_len < umif_pkg::MIN_INTERFACE_LEN) begin
            bad_seen = 1'b1;
            return;
         end
         if (b == umif_pkg::DESC_ENDPOINT && in_midi &&
             desc_len < umif_pkg::MIN_ENDPOINT_LEN) begin
            bad_seen = 1'b1;
            return;
         end
      end else if (off < 8'd8) begin
         field_bytes[3'(off - 8'd2)] = b;
      end

      // total length completes on the fourth header byte
      if (pos == umif_pkg::POS_HEADER_TOTAL) begin
         cfg_total = {b, field_bytes[0]};
         if (cfg_total < 16'(umif_pkg::MIN_CONFIG_LEN) || 16'(desc_len) > cfg_total) begin
            bad_seen = 1'b1;
            return;
         end
      end

      if ({1'b0, off} + 9'd1 >= {1'b0, desc_len}) begin
         close_descriptor();
         desc_off = 8'd0;
      end else begin
         desc_off = off + 8'd1;
      end
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic is_last);
      int                     count;
      umif_pkg::rsp_item_type verdict;
      if (!bad_seen && (scan_pos < umif_pkg::POS_HEADER_END || scan_pos < cfg_total)) begin
         parse_byte(b);
      end
      count = int'(scan_pos) + 1;
      if (scan_pos != umif_pkg::POS_MAX) begin
         scan_pos = scan_pos + 16'd1;
      end
      if (is_last) begin
         verdict = '0;
         if (bad_seen || count < int'(umif_pkg::MIN_CONFIG_LEN) || count < int'(cfg_total)) begin
            verdict.status = umif_pkg::STATUS_MALFORMED;
         end else begin
            promote_candidate();
            if (held_rec.in_ep != 8'd0 || held_rec.out_ep != 8'd0) begin
               verdict.status = umif_pkg::STATUS_FOUND;
               verdict.rec    = held_rec;
            end else begin
               verdict.status = umif_pkg::STATUS_NONE;
            end
         end
         awaited_verdicts.push_back(verdict);
         clear_parser();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // buffer construction
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] rnd_byte();
      return 8'($urandom);
   endfunction

   // queue the draft as requests, tlast on its final byte
   function automatic void send_draft();
      beat_type beat;
      for (int i = 0; i < draft.size(); i++) begin
         beat.data    = draft[i];
         beat.is_last = (i == draft.size() - 1);
         req_backlog.push_back(beat);
      end
   endfunction

   function automatic void begin_config(input int len);
      draft.delete();
      draft.push_back(8'(len));
      draft.push_back(umif_pkg::DESC_CONFIG);
      draft.push_back(8'd0);
      draft.push_back(8'd0);
      for (int i = 4; i < len; i++) draft.push_back(rnd_byte());
   endfunction

   function automatic void seal_total(input logic [15:0] total);
      draft[2] = total[7:0];
      draft[3] = total[15:8];
   endfunction

   function automatic void add_tail(input int n);
      for (int i = 0; i < n; i++) draft.push_back(rnd_byte());
   endfunction

   // total length covers the draft so far, then optional bytes past it
   function automatic void finish_config(input int tail);
      seal_total(16'(draft.size()));
      add_tail(tail);
      send_draft();
   endfunction

   // a length below nine truncates the descriptor
   function automatic void add_interface(input logic [7:0] num, input logic [7:0] alt,
                                         input logic [7:0] cls, input logic [7:0] sub,
                                         input logic [7:0] proto, input int len);
      logic [7:0] body [9];
      body = '{8'(len), umif_pkg::DESC_INTERFACE, num, alt, rnd_byte(), cls, sub, proto,
               rnd_byte()};
      for (int i = 0; i < len; i++) draft.push_back((i < 9) ? body[i] : rnd_byte());
   endfunction

   // plain midi streaming interface of standard length
   function automatic void add_midi_if(input logic [7:0] num, input logic [7:0] alt);
      add_interface(num, alt, umif_pkg::CLASS_AUDIO, umif_pkg::SUBCLASS_MIDI_STREAMING,
                    umif_pkg::PROTOCOL_NONE, 9);
   endfunction

   function automatic void add_endpoint(input logic [7:0] addr, input logic [7:0] attr,
                                        input logic [15:0] mps, input int len);
      logic [7:0] body [7];
      body = '{8'(len), umif_pkg::DESC_ENDPOINT, addr, attr, mps[7:0], mps[15:8], rnd_byte()};
      for (int i = 0; i < len; i++) draft.push_back((i < 7) ? body[i] : rnd_byte());
   endfunction

   function automatic void add_blob(input logic [7:0] kind, input int len);
      draft.push_back(8'(len));
      draft.push_back(kind);
      for (int i = 2; i < len; i++) draft.push_back(rnd_byte());
   endfunction

   function automatic logic [7:0] rnd_ep_addr();
      logic [7:0] a;
      a = rnd_byte();
      if ($urandom_range(0, 3) != 0) a[6:4] = 3'd0;
      if ($urandom_range(0, 7) == 0) a[3:0] = 4'd0;
      return a;
   endfunction

   function automatic logic [7:0] rnd_ep_attr();
      logic [7:0] a;
      a = rnd_byte();
      if ($urandom_range(0, 3) != 0) a[7:2] = 6'd0;
      if ($urandom_range(0, 2) != 0) a[1] = 1'b1;   // lean towards bulk and interrupt
      return a;
   endfunction

   function automatic logic [15:0] rnd_mps();
      case ($urandom_range(0, 7))
         0:       return 16'($urandom_range(0, 3));
         1:       return 16'($urandom);
         default: return 16'($urandom_range(4, 512));
      endcase
   endfunction

   // interfaces, mostly midi streaming, each with optional class-specific and endpoint
   // descriptors of random shape
   function automatic void add_random_body();
      int         n_if;
      int         n_ep;
      logic [7:0] cls;
      logic [7:0] sub;
      logic [7:0] proto;
      n_if = $urandom_range(1, 3);
      for (int i = 0; i < n_if; i++) begin
         cls   = umif_pkg::CLASS_AUDIO;
         sub   = umif_pkg::SUBCLASS_MIDI_STREAMING;
         proto = umif_pkg::PROTOCOL_NONE;
         case ($urandom_range(0, 9))
            6: sub = SUBCLASS_AUDIO_CONTROL;
            7: proto = 8'($urandom_range(1, 255));
            8: cls = rnd_byte();
            9: begin
               cls   = rnd_byte();
               sub   = rnd_byte();
               proto = rnd_byte();
            end
            default: ;
         endcase
         add_interface(($urandom_range(0, 7) == 0) ? rnd_byte() : 8'(i),
                       8'($urandom_range(0, 2)), cls, sub, proto,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : 9);
         if ($urandom_range(0, 2) == 0) add_blob(DESC_CS_INTERFACE, $urandom_range(2, 9));
         n_ep = $urandom_range(0, 3);
         for (int j = 0; j < n_ep; j++) begin
            add_endpoint(rnd_ep_addr(), rnd_ep_attr(), rnd_mps(),
                         $urandom_range(0, 1) ? 9 : 7);
            if ($urandom_range(0, 2) == 0) add_blob(DESC_CS_ENDPOINT, $urandom_range(2, 6));
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // a request taken at this edge goes through the mirror first
         if (req_tvalid && req_tready) begin
            predict_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0 || req_backlog.size() == 0) begin
               if (gap_left != 0) gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else begin
               beat = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat.data;
               req_tlast  <= beat.is_last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
               end else begin
                  burst_left = burst_left - 1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response side: ready follows a mode that is drawn anew whenever its countdown runs out
   // (always ready, coin toss, one in eight, alternate cycles)
   // ---------------------------------------------------------------------------
   logic [1:0] stall_mode = 2'd0;
   logic [8:0] mode_left  = 9'd0;

   always @(posedge clock) begin
      if (mode_left == 9'd0) begin
         stall_mode <= 2'($urandom_range(0, 3));
         mode_left  <= 9'($urandom_range(32, 256));
      end else begin
         mode_left <= mode_left - 9'd1;
      end
      case (stall_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (mode_left[2:0] == 3'd0);
         default: rsp_tready <= mode_left[0];
      endcase
   end

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("response %0d %s: got %0h, expected %0h", rsp_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_responses
      umif_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_verdicts.size() == 0) begin
            flag_mismatch("with none awaited, status", rsp_tdata[1:0], 0);
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_tdata[1:0] != want.status)
               flag_mismatch("status", rsp_tdata[1:0], want.status);
            if (rsp_tdata[9:2] != want.rec.num)
               flag_mismatch("interface_number", rsp_tdata[9:2], want.rec.num);
            if (rsp_tdata[17:10] != want.rec.alt)
               flag_mismatch("alternate_setting", rsp_tdata[17:10], want.rec.alt);
            if (rsp_tdata[25:18] != want.rec.in_ep)
               flag_mismatch("in_endpoint", rsp_tdata[25:18], want.rec.in_ep);
            if (rsp_tdata[36:26] != want.rec.in_mps)
               flag_mismatch("in_max_packet", rsp_tdata[36:26], want.rec.in_mps);
            if (rsp_tdata[44:37] != want.rec.out_ep)
               flag_mismatch("out_endpoint", rsp_tdata[44:37], want.rec.out_ep);
            if (rsp_tdata[55:45] != want.rec.out_mps)
               flag_mismatch("out_max_packet", rsp_tdata[55:45], want.rec.out_mps);
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_usb_midi_interface_finder: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int          base;
      int          bufs;
      int          k;
      logic [15:0] t;
      clear_parser();

      // found: one midi interface with a bulk in and a bulk out endpoint
      begin_config(9);
      add_midi_if(8'd1, 8'd0);
      add_endpoint(8'h81, ATTR_BULK, 16'd64, 9);
      add_endpoint(8'h02, ATTR_BULK, 16'd64, 9);
      finish_config(0);

      // header alone, nothing usable
      begin_config(9);
      finish_config(0);

      // single byte flagged last, and a buffer cut short inside the header
      draft.delete();
      draft.push_back(umif_pkg::MIN_CONFIG_LEN);
      send_draft();
      begin_config(9);
      seal_total(16'd9);
      repeat (4) draft.pop_back();
      send_draft();

      // wrong header type
      begin_config(9);
      seal_total(16'd9);
      draft[1] = umif_pkg::DESC_INTERFACE;
      send_draft();

      // bytes past the total length, the last of them flagged
      begin_config(9);
      add_midi_if(8'd0, 8'd0);
      add_endpoint(8'h81, ATTR_INTR, 16'd8, 7);
      finish_config(3);

      // field extremes, every endpoint rejection rule, and a direction already taken
      begin_config(9);
      add_midi_if(8'hFF, 8'hFF);
      add_endpoint(8'h80, ATTR_BULK, 16'd64, 7);                  // endpoint number zero
      add_endpoint(8'h83, {6'd0, XFER_ISOCHRONOUS}, 16'd64, 7);
      add_endpoint(8'h84, {6'd0, XFER_CONTROL}, 16'd64, 7);
      add_endpoint(8'h01, ATTR_BULK, 16'd3, 7);                   // packet too small
      add_endpoint(8'h8F, 8'hFF, 16'hFFFF, 7);                    // size masked to 11 bits
      add_endpoint(8'h7F, ATTR_INTR, 16'd4, 7);
      add_endpoint(8'h0E, ATTR_BULK, 16'd512, 7);                 // out already taken
      finish_config(0);

      // one-way candidate replaced by a two-way one, which a later one keeps
      begin_config(9);
      add_midi_if(8'd0, 8'd0);
      add_endpoint(8'h81, ATTR_BULK, 16'd32, 7);
      add_interface(8'd1, 8'd0, umif_pkg::CLASS_AUDIO, SUBCLASS_AUDIO_CONTROL,
                    umif_pkg::PROTOCOL_NONE, 9);
      add_endpoint(8'h82, ATTR_BULK, 16'd16, 7);
      add_midi_if(8'd2, 8'd1);
      add_endpoint(8'h83, ATTR_BULK, 16'd64, 7);
      add_endpoint(8'h03, ATTR_BULK, 16'd64, 7);
      add_midi_if(8'd3, 8'd0);
      add_endpoint(8'h84, ATTR_BULK, 16'd64, 7);
      add_endpoint(8'h04, ATTR_BULK, 16'd64, 7);
      finish_config(0);

      // midi subclass with a nonzero protocol opens no candidate
      begin_config(9);
      add_interface(8'd0, 8'd0, umif_pkg::CLASS_AUDIO, umif_pkg::SUBCLASS_MIDI_STREAMING,
                    8'd1, 9);
      add_endpoint(8'h81, ATTR_BULK, 16'd64, 7);
      finish_config(0);

      // short endpoint inside a midi interface, later bytes ignored until last
      begin_config(9);
      add_midi_if(8'd0, 8'd0);
      add_endpoint(8'h81, ATTR_BULK, 16'd64, 6);
      add_endpoint(8'h02, ATTR_BULK, 16'd64, 7);
      finish_config(0);

      // a long run of ignored bytes past the total length
      begin_config(9);
      finish_config(LONG_RUN);

      // random buffers: mostly well formed, the rest broken or noise
      base = req_backlog.size();
      bufs = 0;
      while (req_backlog.size() - base < RANDOM_BYTES || bufs < RANDOM_BUFS) begin
         k = $urandom_range(0, 19);
         if (k < 11) begin
            begin_config(($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : 9);
            add_random_body();
            finish_config(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
         end else begin
            begin_config(9);
            case (k)
               11: begin   // cut short anywhere
                  add_random_body();
                  seal_total(16'(draft.size()));
                  repeat ($urandom_range(1, draft.size() - 1)) draft.pop_back();
               end
               12: begin   // one byte corrupted
                  add_random_body();
                  seal_total(16'(draft.size()));
                  draft[$urandom_range(0, draft.size() - 1)] = rnd_byte();
               end
               13: begin   // header type other than configuration
                  add_random_body();
                  seal_total(16'(draft.size()));
                  draft[1] = rnd_byte();
                  if (draft[1] == umif_pkg::DESC_CONFIG) draft[1] = umif_pkg::DESC_INTERFACE;
               end
               14: begin   // header length below nine
                  add_random_body();
                  seal_total(16'(draft.size()));
                  draft[0] = 8'($urandom_range(0, 8));
               end
               15: begin   // total length too small, beyond the buffer, or below the header
                  add_random_body();
                  case ($urandom_range(0, 3))
                     0:       t = 16'($urandom_range(0, 8));
                     1:       t = 16'($urandom);
                     2: begin
                        draft[0] = 8'($urandom_range(10, 60));
                        t = 16'($urandom_range(9, draft[0] - 1));
                     end
                     default: t = 16'(draft.size() + $urandom_range(1, 300));
                  endcase
                  seal_total(t);
               end
               16: begin   // sub-descriptor of length zero or one
                  add_random_body();
                  draft.push_back(8'($urandom_range(0, 1)));
                  add_tail($urandom_range(1, 12));
                  seal_total(16'(draft.size()));
               end
               17: begin   // sub-descriptor running past the total length, or ending on it at length three
                  add_random_body();
                  draft.push_back(8'($urandom_range(3, 40)));
                  draft.push_back(rnd_byte());
                  draft.push_back(rnd_byte());
                  seal_total(16'(draft.size()));
               end
               18: begin   // interface too short, or endpoint too short within midi
                  if ($urandom_range(0, 1)) begin
                     add_interface(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                                   rnd_byte(), $urandom_range(2, 8));
                  end else begin
                     add_midi_if(8'd0, 8'd0);
                     add_endpoint(rnd_ep_addr(), rnd_ep_attr(), rnd_mps(),
                                  $urandom_range(2, 6));
                  end
                  add_random_body();
                  seal_total(16'(draft.size()));
               end
               default: begin   // plain noise
                  draft.delete();
                  add_tail($urandom_range(1, 40));
               end
            endcase
            // a few bytes past the total length after a broken sub-descriptor
            if (k == 16 && $urandom_range(0, 1)) add_tail($urandom_range(1, 3));
            send_draft();
         end
         bufs++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // drain: every request taken and every verdict seen
      while (req_backlog.size() != 0 || req_tvalid || awaited_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_verdicts.size() == 0) begin
         $display("tb_usb_midi_interface_finder: done, clean");
      end else begin
         $display("tb_usb_midi_interface_finder: done, errors");
      end
      $finish;
   end

endmodule
